/* hdl/sotp_pkg.sv */
`timescale 1ns / 1ps

package sotp_pkg;

  // store geometry
  localparam int unsigned NUM_COEFFS = 576;
  localparam int unsigned NUM_WORDS  = 36;
  localparam int unsigned CIDX_W     = 10;
  localparam int unsigned WIDX_W     = 6;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned K_W        = 4;
  localparam int unsigned CODE_W     = 2;

  // action codes
  typedef enum logic [1:0] {
    ACT_ENCODE = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_DECODE = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  // interleaved coefficient position of bit k of word w
  function automatic logic [CIDX_W-1:0] slot_of(input logic [WIDX_W-1:0] w,
                                                input logic [K_W-1:0] k);
    logic [CIDX_W-1:0] p;
    if (w[5] == 1'b0) begin
      p = {1'b0, w[4], k, w[3:0]};
    end else begin
      p = {1'b1, 3'b000, k, w[1:0]};
    end
    return p;
  endfunction

  // stored code plus high bit falls outside zero or one
  function automatic logic sum_fails(input logic [CODE_W-1:0] c, input logic h);
    logic f;
    if (h) begin
      f = (c == 2'b10) || (c == 2'b01);
    end else begin
      f = (c == 2'b10) || (c == 2'b11);
    end
    return f;
  endfunction

endpackage

/* hdl/sotp_if.sv */
`timescale 1ns / 1ps

// input channel
interface sotp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [5:0]         word_index;
  logic [15:0]        message_word;
  logic [15:0]        rand_low;
  logic [15:0]        rand_high;
  logic [9:0]         coeff_index;
  logic signed [15:0] coeff_in;

  modport source (
    output valid, action, word_index, message_word, rand_low, rand_high,
           coeff_index, coeff_in,
    input  ready
  );
  modport sink (
    input  valid, action, word_index, message_word, rand_low, rand_high,
           coeff_index, coeff_in,
    output ready
  );
endinterface

// result channel
interface sotp_out_if;
  logic              valid;
  logic              ready;
  logic [9:0]        out_index;
  logic signed [1:0] out_coeff;
  logic [15:0]       decoded_word;
  logic              word_fail;
  logic              last;

  modport source (
    output valid, out_index, out_coeff, decoded_word, word_fail, last,
    input  ready
  );
  modport sink (
    input  valid, out_index, out_coeff, decoded_word, word_fail, last,
    output ready
  );
endinterface

/* hdl/sotp_ram.sv */
`timescale 1ns / 1ps

module sotp_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 576
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/sotp_ternary_codec.sv */
`timescale 1ns / 1ps

// Ternary SOTP codec over 36 sixteen-bit message words and a 576-entry
// store of 2-bit coefficients. A load transaction writes one store entry.
// An encode transaction is accepted, then gives one coefficient per cycle
// while the result channel takes them, from the shared position and bit
// select unit, sixteen results with last on the sixteenth. A decode
// transaction makes sixteen reads through the single read port of the
// store, waits for the last read data, then hands the word and its fail
// flag to the output register. Back-pressure on the result channel
// stretches either transaction. Encode or decode with a word index above
// 35, action 3, or a load beyond the store gives no result.
// The store is not cleared: entries read before being loaded are undefined.
module sotp_ternary_codec (
  input  logic       clk_i,
  input  logic       rst_ni,
  sotp_in_if.sink    in_i,
  sotp_out_if.source out_o
);

  import sotp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ENC  = 2'd1;
  localparam logic [1:0] ST_DEC  = 2'd2;
  localparam logic [1:0] ST_DOUT = 2'd3;

  localparam logic [K_W-1:0] K_LAST = {K_W{1'b1}};

  logic [1:0]        state_q, state_d;
  logic [K_W-1:0]    k_q, k_d;
  logic [WIDX_W-1:0] w_q;
  logic [WORD_W-1:0] t1_q, lo_q, hi_q;

  logic              rd_pend_q;
  logic [K_W-1:0]    rd_k_q;
  logic [WORD_W-1:0] word_q;
  logic              fail_q;

  logic              out_valid_q;
  logic [CIDX_W-1:0] out_index_q;
  logic [1:0]        out_coeff_q;
  logic [WORD_W-1:0] out_word_q;
  logic              out_fail_q;
  logic              out_last_q;

  logic              in_fire, out_free, word_ok;
  logic              enc_load, dec_load, rd_en, ram_we;
  logic [CIDX_W-1:0] slot;
  logic [CODE_W-1:0] rd_data;
  logic              bit_a, bit_b;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign word_ok  = in_i.word_index < WIDX_W'(NUM_WORDS);

  // shared position and bit select unit
  assign slot  = slot_of(w_q, k_q);
  assign bit_a = t1_q[k_q];
  assign bit_b = hi_q[k_q];

  assign enc_load = (state_q == ST_ENC) && out_free;
  assign dec_load = (state_q == ST_DOUT) && !rd_pend_q && out_free;
  assign rd_en    = (state_q == ST_DEC);
  assign ram_we   = in_fire && (action_e'(in_i.action) == ACT_LOAD) &&
                    (in_i.coeff_index < CIDX_W'(NUM_COEFFS));

  // sequencer
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        k_d = '0;
        if (in_fire && word_ok) begin
          if (action_e'(in_i.action) == ACT_ENCODE) begin
            state_d = ST_ENC;
          end else if (action_e'(in_i.action) == ACT_DECODE) begin
            state_d = ST_DEC;
          end
        end
      end
      ST_ENC: begin
        if (enc_load) begin
          k_d = k_q + 1'b1;
          if (k_q == K_LAST) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_DEC: begin
        k_d = k_q + 1'b1;
        if (k_q == K_LAST) begin
          state_d = ST_DOUT;
        end
      end
      ST_DOUT: begin
        if (dec_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      k_q       <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      rd_pend_q <= rd_en;
    end
  end

  // transaction operands
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      w_q  <= in_i.word_index;
      t1_q <= in_i.message_word ^ in_i.rand_low;
      lo_q <= in_i.rand_low;
      hi_q <= in_i.rand_high;
    end
    if (rd_en) begin
      rd_k_q <= k_q;
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);

  // coefficient store
  sotp_ram #(
    .Width (CODE_W),
    .Depth (NUM_COEFFS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_i.coeff_index),
    .wdata_i (in_i.coeff_in[CODE_W-1:0]),
    .re_i    (rd_en),
    .raddr_i (slot),
    .rdata_o (rd_data)
  );

  // decode accumulation, one stored coefficient per cycle
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      word_q <= '0;
      fail_q <= 1'b0;
    end else if (rd_pend_q) begin
      word_q[rd_k_q] <= hi_q[rd_k_q] ^ rd_data[0] ^ lo_q[rd_k_q];
      fail_q         <= fail_q | sum_fails(rd_data, hi_q[rd_k_q]);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (enc_load || dec_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enc_load) begin
      out_index_q <= slot;
      out_coeff_q <= {bit_b & ~bit_a, bit_a ^ bit_b};
      out_word_q  <= '0;
      out_fail_q  <= 1'b0;
      out_last_q  <= (k_q == K_LAST);
    end else if (dec_load) begin
      out_index_q <= '0;
      out_coeff_q <= '0;
      out_word_q  <= word_q;
      out_fail_q  <= fail_q;
      out_last_q  <= 1'b1;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_index    = out_index_q;
  assign out_o.out_coeff    = out_coeff_q;
  assign out_o.decoded_word = out_word_q;
  assign out_o.word_fail    = out_fail_q;
  assign out_o.last         = out_last_q;

`ifndef SYNTHESIS
  // read data only returns while a decode is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == ST_DEC || state_q == ST_DOUT))
    else $error("store read data outside decode");

  // every decode sweep cycle leaves a read pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DEC) |=> rd_pend_q)
    else $error("decode read lost");

  // final coefficient of an encode carries last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (enc_load && k_q == K_LAST) |=> (out_valid_q && out_last_q))
    else $error("encode last missing");

  // store written only between transactions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_IDLE && !rd_pend_q))
    else $error("store write while busy");
`endif

endmodule
